FILE: sv/sba_pkg.sv
// Shared constants, command and status codes, and size-class helpers for the
// slab block allocator. No dependencies.
package sba_pkg;

  localparam int DEF_PAGES      = 64;
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int HDR_BYTES      = 40;
  localparam int MAX_REQ        = 64;
  localparam int CLASSES        = 6;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOOBIG   = 3'd1;
  localparam logic [2:0] ST_NOPAGE   = 3'd2;
  localparam logic [2:0] ST_NOTSLAB  = 3'd3;
  localparam logic [2:0] ST_MISALIGN = 3'd4;

  localparam logic REG_ARENA = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // class code as stored in a page record may be any 3-bit value; fold to 0..5
  function automatic logic [2:0] mod6(input logic [2:0] c);
    logic [2:0] r;
    r = c;
    if (c == 3'd6) r = 3'd0;
    else if (c == 3'd7) r = 3'd1;
    return r;
  endfunction

  function automatic logic [6:0] class_bytes(input logic [2:0] c);
    logic [6:0] b;
    case (mod6(c))
      3'd0:    b = 7'd8;
      3'd1:    b = 7'd16;
      3'd2:    b = 7'd24;
      3'd3:    b = 7'd32;
      3'd4:    b = 7'd48;
      default: b = 7'd64;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] class_of(input logic [15:0] size);
    logic [2:0] c;
    if (size <= 16'd8) c = 3'd0;
    else if (size <= 16'd16) c = 3'd1;
    else if (size <= 16'd24) c = 3'd2;
    else if (size <= 16'd32) c = 3'd3;
    else if (size <= 16'd48) c = 3'd4;
    else c = 3'd5;
    return c;
  endfunction

endpackage

FILE: sv/sba_slot_dec.sv
// Block offset to slot decode: strips the page header and divides by the
// class size (multiples of 8; thirds via reciprocal). Uses sba_pkg.
module sba_slot_dec #(
  parameter int PBW = 12
) (
  input  logic             clk,
  input  logic             load,
  input  logic [PBW-1:0]   off,
  input  logic [2:0]       cls,
  output logic             aligned,
  output logic [PBW-4:0]   slot
);
  localparam int YW = PBW - 3;
  localparam int K  = YW + 2;
  localparam int RC = ((2 ** K) + 2) / 3;

  logic          below_hdr;
  logic          low_ok;
  logic [YW-1:0] y;
  logic [PBW-1:0] rel;
  logic [YW+K-1:0] prod;
  logic [YW-1:0] q3;
  logic [YW-1:0] r3;

  assign rel = off - PBW'(sba_pkg::HDR_BYTES);

  always_ff @(posedge clk) begin
    if (load) begin
      below_hdr <= off < PBW'(sba_pkg::HDR_BYTES);
      low_ok    <= rel[2:0] == 3'd0;
      y         <= rel[PBW-1:3];
    end
  end

  assign prod = (YW+K)'(y) * (YW+K)'(RC);
  assign q3   = prod[YW+K-1:K];
  assign r3   = y - YW'(q3 * YW'(3));

  always_comb begin
    aligned = low_ok && !below_hdr;
    slot    = y;
    case (cls)
      3'd0: slot = y;
      3'd1: begin
        aligned = aligned && !y[0];
        slot    = y >> 1;
      end
      3'd2: begin
        aligned = aligned && (r3 == '0);
        slot    = q3;
      end
      3'd3: begin
        aligned = aligned && (y[1:0] == 2'd0);
        slot    = y >> 2;
      end
      3'd4: begin
        aligned = aligned && (r3 == '0) && !q3[0];
        slot    = q3 >> 1;
      end
      default: begin
        aligned = aligned && (y[2:0] == 3'd0);
        slot    = y >> 3;
      end
    endcase
  end

endmodule

FILE: sv/slab_block_allocator.sv
// Slab block allocator top level: command sequencer, page record memory,
// block link memory, class stacks and APB registers. Uses sba_pkg, sba_slot_dec.
//
//  channel  | beat                          | handshake
//  ---------+-------------------------------+---------------------
//  in       | cmd, req_size, block_addr     | in_valid / in_ready
//  out      | status, result_addr, usable   | out_valid / out_ready
//  cfg      | paddr, pwdata, prdata         | APB, pready tied high
//
// One command at a time: accept, decode, record read, optional link read,
// write-back. The link read is made only when an allocate takes a block
// from the page's free list (dependent link read); a command refused at
// decode (size, pool, address, unknown code) goes from decode to write-back.
// A new command is taken while the previous result waits in the output
// register; write-back stalls only if that register is still full.
// Reset: class stacks empty, no pages in use, arena_page 0, page_limit 64.
// Memories need no clearing: a page record is written when the page is issued.
module slab_block_allocator #(
  parameter int PAGES      = sba_pkg::DEF_PAGES,
  parameter int PAGE_BYTES = sba_pkg::DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [15:0] req_size,
  input  logic [47:0] block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [47:0] result_addr,
  output logic [6:0]  usable_bytes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int HDR       = sba_pkg::HDR_BYTES;
  localparam int PBW       = $clog2(PAGE_BYTES);
  localparam int SLOTS_MAX = (PAGE_BYTES - HDR) / 8;
  localparam int SW        = $clog2(SLOTS_MAX + 1);
  localparam int YW        = PBW - 3;
  localparam int PGW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int PUW       = $clog2(PAGES + 1);
  localparam int LMW       = (PUW > 7) ? PUW : 7;
  localparam int LDEPTH    = PAGES * SLOTS_MAX;
  localparam int LW        = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int APW       = 48 - PBW;
  localparam int CW        = (APW > 36) ? APW + 1 : 37;
  localparam int NB0       = (PAGE_BYTES - HDR) / 8;
  localparam int NB1       = (PAGE_BYTES - HDR) / 16;
  localparam int NB2       = (PAGE_BYTES - HDR) / 24;
  localparam int NB3       = (PAGE_BYTES - HDR) / 32;
  localparam int NB4       = (PAGE_BYTES - HDR) / 48;
  localparam int NB5       = (PAGE_BYTES - HDR) / 64;

  typedef struct packed {
    logic [2:0]     cls;
    logic [SW-1:0]  cnt;
    logic           head_v;
    logic [SW-1:0]  head;
    logic [SW-1:0]  wm;
    logic           nxt_v;
    logic [PGW-1:0] nxt;
  } rec_t;

  typedef struct packed {
    logic          v;
    logic [SW-1:0] slot;
  } link_t;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_REC, S_LNK, S_WB} state_t;

  function automatic logic [SW-1:0] blocks_of(input logic [2:0] c);
    logic [SW-1:0] n;
    case (c)
      3'd0:    n = SW'(NB0);
      3'd1:    n = SW'(NB1);
      3'd2:    n = SW'(NB2);
      3'd3:    n = SW'(NB3);
      3'd4:    n = SW'(NB4);
      default: n = SW'(NB5);
    endcase
    return n;
  endfunction

  function automatic logic [LW-1:0] link_idx(input logic [PGW-1:0] p,
                                             input logic [SW-1:0] s);
    return LW'(LW'(p) * LW'(SLOTS_MAX) + LW'(s));
  endfunction

  state_t         state;
  logic [35:0]    arena_page;
  logic [6:0]     page_limit;
  logic [PUW-1:0] pages_used;
  logic [PGW-1:0] ctop [sba_pkg::CLASSES];
  logic [sba_pkg::CLASSES-1:0] ctop_v;

  logic [1:0]     c_cmd;
  logic [15:0]    c_size;
  logic [47:0]    c_addr;
  logic [2:0]     cls;
  logic [PGW-1:0] pg;
  logic [SW-1:0]  slot;
  logic [2:0]     st;
  logic           fresh;
  logic           popped;
  logic           wr_rec;
  rec_t           rec;

  rec_t           rec_mem [PAGES];
  rec_t           rec_q;
  link_t          link_mem [LDEPTH];
  link_t          link_q;

  // decode-stage signals
  logic [2:0]     d_cls;
  logic [CW-1:0]  d_page;
  logic [CW-1:0]  d_diff;
  logic           d_in_range;
  logic [LMW-1:0] avail;
  logic [PGW-1:0] d_pg;

  // record-stage signals
  rec_t           r;
  rec_t           init_rec;
  logic [2:0]     r_cls;
  logic [SW-1:0]  r_nb;
  logic           dec_aligned;
  logic [YW-1:0]  dec_slot;

  // write-back signals
  rec_t           w_rec;
  logic           w_push;
  logic           wb_fire;
  logic           rec_we;
  logic           link_we;
  logic [LW-1:0]  link_raddr;
  logic [47:0]    alloc_addr;

  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_page <= '0;
      page_limit <= 7'd64;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        sba_pkg::REG_ARENA: arena_page <= pwdata[35:0];
        sba_pkg::REG_LIMIT: page_limit <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      sba_pkg::REG_ARENA: prdata = {28'd0, arena_page};
      sba_pkg::REG_LIMIT: prdata = {57'd0, page_limit};
      default:            prdata = '0;
    endcase
  end

  // ---------------- decode ----------------
  assign d_cls      = sba_pkg::class_of(c_size);
  assign d_page     = CW'(c_addr[47:PBW]);
  assign d_diff     = d_page - CW'(arena_page);
  assign d_in_range = (d_page >= CW'(arena_page)) && (d_diff < CW'(pages_used));
  assign avail      = (LMW'(page_limit) < LMW'(PAGES)) ? LMW'(page_limit) : LMW'(PAGES);

  always_comb begin
    d_pg = d_diff[PGW-1:0];
    if (c_cmd == sba_pkg::CMD_ALLOC) begin
      d_pg = ctop_v[d_cls] ? ctop[d_cls] : pages_used[PGW-1:0];
    end
  end

  sba_slot_dec #(.PBW(PBW)) u_slot_dec (
    .clk     (clk),
    .load    (state == S_DEC),
    .off     (c_addr[PBW-1:0]),
    .cls     (r_cls),
    .aligned (dec_aligned),
    .slot    (dec_slot)
  );

  // ---------------- record stage ----------------
  always_comb begin
    init_rec        = '0;
    init_rec.cls    = cls;
    init_rec.cnt    = blocks_of(cls);
    r               = fresh ? init_rec : rec_q;
    r_cls           = sba_pkg::mod6(r.cls);
    r_nb            = blocks_of(r_cls);
  end

  assign link_raddr = link_idx(pg, r.head);

  // ---------------- write-back ----------------
  assign wb_fire = (state == S_WB) && (!out_valid || out_ready);

  always_comb begin
    w_rec  = rec;
    w_push = 1'b0;
    if (st == sba_pkg::ST_OK && c_cmd == sba_pkg::CMD_ALLOC) begin
      if (rec.cnt != '0) w_rec.cnt = rec.cnt - 1'b1;
      w_push = (w_rec.cnt != '0);
    end else if (st == sba_pkg::ST_OK && c_cmd == sba_pkg::CMD_FREE) begin
      w_rec.head_v = 1'b1;
      w_rec.head   = slot;
      w_push       = (rec.cnt == '0);
      if (rec.cnt < blocks_of(cls)) w_rec.cnt = rec.cnt + 1'b1;
    end
    if (w_push) begin
      w_rec.nxt_v = ctop_v[cls];
      w_rec.nxt   = ctop[cls];
    end
  end

  assign rec_we  = wb_fire && wr_rec;
  assign link_we = wb_fire && wr_rec && (c_cmd == sba_pkg::CMD_FREE);

  // block offset stays below one page: 16 bits cover the product
  assign alloc_addr = 48'((49'(arena_page) + 49'(pg)) << PBW)
                    + 48'(HDR)
                    + 48'(16'(slot) * 16'(sba_pkg::class_bytes(cls)));

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[pg] <= w_rec;
    rec_q <= rec_mem[d_pg];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_idx(pg, slot)] <= '{v: rec.head_v, slot: rec.head};
    link_q <= link_mem[link_raddr];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pages_used <= '0;
      ctop_v     <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < sba_pkg::CLASSES; i++) ctop[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_cmd  <= cmd;
            c_size <= req_size;
            c_addr <= block_addr;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          cls    <= d_cls;
          pg     <= d_pg;
          fresh  <= 1'b0;
          popped <= 1'b0;
          wr_rec <= 1'b0;
          st     <= sba_pkg::ST_OK;
          state  <= S_REC;
          case (c_cmd)
            sba_pkg::CMD_ALLOC: begin
              if (c_size > 16'(sba_pkg::MAX_REQ)) begin
                st    <= sba_pkg::ST_TOOBIG;
                state <= S_WB;
              end else if (ctop_v[d_cls]) begin
                popped <= 1'b1;
              end else if (LMW'(pages_used) >= avail) begin
                st    <= sba_pkg::ST_NOPAGE;
                state <= S_WB;
              end else begin
                fresh      <= 1'b1;
                pages_used <= pages_used + 1'b1;
              end
            end
            sba_pkg::CMD_FREE, sba_pkg::CMD_QUERY: begin
              if (!d_in_range ||
                  (c_cmd == sba_pkg::CMD_QUERY && c_addr == '0)) begin
                st    <= sba_pkg::ST_NOTSLAB;
                state <= S_WB;
              end
            end
            default: state <= S_WB;
          endcase
        end
        S_REC: begin
          rec   <= r;
          state <= S_WB;
          case (c_cmd)
            sba_pkg::CMD_ALLOC: begin
              if (popped) begin
                ctop[cls]   <= r.nxt;
                ctop_v[cls] <= r.nxt_v;
              end
              wr_rec <= 1'b1;
              if (r.head_v) begin
                slot  <= r.head;
                state <= S_LNK;
              end else if (r.wm < blocks_of(cls)) begin
                slot   <= r.wm;
                rec.wm <= r.wm + 1'b1;
              end else begin
                rec.cnt <= '0;
                st      <= sba_pkg::ST_NOPAGE;
              end
            end
            sba_pkg::CMD_FREE: begin
              cls <= r_cls;
              if (!dec_aligned || (dec_slot >= YW'(r_nb))) begin
                st <= sba_pkg::ST_MISALIGN;
              end else if (dec_slot >= YW'(r.wm)) begin
                st <= sba_pkg::ST_NOTSLAB;
              end else begin
                slot   <= dec_slot[SW-1:0];
                wr_rec <= 1'b1;
              end
            end
            default: cls <= r_cls;
          endcase
        end
        S_LNK: begin
          rec.head_v <= link_q.v;
          rec.head   <= link_q.slot;
          state      <= S_WB;
        end
        S_WB: begin
          if (wb_fire) begin
            if (w_push) begin
              ctop[cls]   <= pg;
              ctop_v[cls] <= 1'b1;
            end
            out_valid    <= 1'b1;
            status       <= st;
            result_addr  <= '0;
            usable_bytes <= '0;
            if (st == sba_pkg::ST_OK && c_cmd == sba_pkg::CMD_ALLOC) begin
              result_addr  <= alloc_addr;
              usable_bytes <= sba_pkg::class_bytes(cls);
            end else if (st == sba_pkg::ST_OK && c_cmd == sba_pkg::CMD_QUERY) begin
              usable_bytes <= sba_pkg::class_bytes(cls);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/sba_checker.sv
// Port-level checks for the slab block allocator, bound to the top level.
// Uses sba_pkg status codes.
module sba_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [47:0] result_addr,
  input logic [6:0]  usable_bytes
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_addr) && $stable(status))
    else $error("result beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sba_pkg::ST_OK |-> result_addr == '0 && usable_bytes == '0)
    else $error("failed command carries data");

  a_addr_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_addr != '0 |-> status == sba_pkg::ST_OK && usable_bytes != '0)
    else $error("block address without size class");

  // one command in flight: no accept right after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while command in flight");

endmodule

bind slab_block_allocator sba_checker u_sba_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .result_addr  (result_addr),
  .usable_bytes (usable_bytes)
);
